// ----- rtl/core/fcurve_pkg.sv -----
// shared constants and types for the fan curve lookup block
package fcurve_pkg;

   // level table registers and their field layout
   localparam int LEVEL_WORDS   = 6;
   localparam int LEVEL_IDX_W   = 3;
   localparam int THR_W         = 8;
   localparam int SPEED_W       = 16;
   localparam int RATIO_W       = 7;
   localparam int COUNT_W       = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 5;

   localparam int DEC_LSB       = 0;
   localparam int INC_LSB       = 8;
   localparam int SPEED_LSB     = 16;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      REG_LEVEL0        = 3'd0,
      REG_LEVEL1        = 3'd1,
      REG_LEVEL2        = 3'd2,
      REG_LEVEL3        = 3'd3,
      REG_LEVEL4        = 3'd4,
      REG_LEVEL5        = 3'd5,
      REG_LEVELS_IN_USE = 3'd6,
      REG_UNUSED        = 3'd7
   } reg_index_type;

   localparam logic [COUNT_W-1:0] LEVELS_RESET = 3'd1;

   typedef logic [CSR_DATA_W-1:0] level_word_type;

   // one input word as it sits in the input register
   typedef struct packed {
      logic [SPEED_W-1:0] current_target_speed;
      logic [RATIO_W-1:0] demand_pct;
   } req_word_type;

endpackage

// ----- rtl/core/fan_curve_hysteresis_lookup_top.sv -----
// fan curve lookup with hysteresis: level table, csr port and two-stage stream pipeline
// a word accepted on req passes the input register, then the result register, before rsp_tvalid
// throughput: one word per cycle while rsp_tready does not stall; the threshold compares and level select
// are combinational between the input register and the result register
// reset: pipeline empty, level words 0, levels_in_use 1, last ratio 0
// csr writes take effect at once; prdata reads back the stored register
module fan_curve_hysteresis_lookup_top #(
   parameter int LEVELS = 6
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: demand_pct [6:0], current_target_speed [22:7], zero pad [23]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata: new_target_speed [15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // rsp_tuser: speed_changed [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [fcurve_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcurve_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcurve_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NW = fcurve_pkg::LEVEL_WORDS;
   localparam int IW = fcurve_pkg::LEVEL_IDX_W;
   localparam int CW = fcurve_pkg::COUNT_W;
   localparam int SW = fcurve_pkg::SPEED_W;
   localparam int RW = fcurve_pkg::RATIO_W;
   localparam int TW = fcurve_pkg::THR_W;
   localparam logic [CW-1:0] LEVELS_MAX = CW'(LEVELS);
   localparam logic [CW-1:0] WORDS_MAX  = CW'(NW);
   localparam int CSR_ADDR_W_HI = fcurve_pkg::CSR_ADDR_W - 1;

   // configuration registers
   fcurve_pkg::level_word_type level_ff [NW];
   fcurve_pkg::level_word_type level_in [NW];
   logic [CW-1:0]              count_ff, count_in;

   // pipeline registers
   logic                     s1_valid_ff, s1_valid_in;
   fcurve_pkg::req_word_type s1_word_ff, s1_word_in;
   logic                     out_valid_ff, out_valid_in;
   logic [SW-1:0]            out_speed_ff, out_speed_in;
   logic                     out_changed_ff, out_changed_in;
   logic [RW-1:0]            last_ratio_ff, last_ratio_in;

   fcurve_pkg::reg_index_type csr_index;
   logic                      csr_write;
   logic                      s1_advance;

   logic [CW-1:0]  n_levels;
   logic [TW-1:0]  ratio_ext;
   logic [IW-1:0]  sel_fall;
   logic [IW-1:0]  sel_rise;
   logic           rise_run;
   logic [IW-1:0]  sel;
   logic [SW-1:0]  speed;
   logic [TW-1:0]  dec_thr [NW];
   logic [TW-1:0]  inc_thr [NW];
   logic [SW-1:0]  lvl_speed [NW];

   assign csr_index  = fcurve_pkg::reg_index_type'(csr_paddr[CSR_ADDR_W_HI:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         fcurve_pkg::REG_LEVEL0:        csr_prdata = level_ff[0];
         fcurve_pkg::REG_LEVEL1:        csr_prdata = level_ff[1];
         fcurve_pkg::REG_LEVEL2:        csr_prdata = level_ff[2];
         fcurve_pkg::REG_LEVEL3:        csr_prdata = level_ff[3];
         fcurve_pkg::REG_LEVEL4:        csr_prdata = level_ff[4];
         fcurve_pkg::REG_LEVEL5:        csr_prdata = level_ff[5];
         fcurve_pkg::REG_LEVELS_IN_USE: csr_prdata = {{(fcurve_pkg::CSR_DATA_W-CW){1'b0}},
                                                      count_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         level_in[i] = level_ff[i];
      end
      count_in = count_ff;
      if (csr_write) begin
         case (csr_index)
            fcurve_pkg::REG_LEVEL0:        level_in[0] = csr_pwdata;
            fcurve_pkg::REG_LEVEL1:        level_in[1] = csr_pwdata;
            fcurve_pkg::REG_LEVEL2:        level_in[2] = csr_pwdata;
            fcurve_pkg::REG_LEVEL3:        level_in[3] = csr_pwdata;
            fcurve_pkg::REG_LEVEL4:        level_in[4] = csr_pwdata;
            fcurve_pkg::REG_LEVEL5:        level_in[5] = csr_pwdata;
            fcurve_pkg::REG_LEVELS_IN_USE: count_in = csr_pwdata[CW-1:0];
            default:                       count_in = count_ff;
         endcase
      end
   end

   // handshake: stage 1 moves on when the result register is empty or being drained
   assign s1_advance = ~out_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_word_in  = fcurve_pkg::req_word_type'(req_tdata[RW+SW-1:0]);
      end
   end

   // level table fields
   always_comb begin
      for (int i = 0; i < NW; i++) begin
         dec_thr[i]   = level_ff[i][fcurve_pkg::DEC_LSB +: TW];
         inc_thr[i]   = level_ff[i][fcurve_pkg::INC_LSB +: TW];
         lvl_speed[i] = level_ff[i][fcurve_pkg::SPEED_LSB +: SW];
      end
   end

   // number of levels in use, clamped to one and to the table
   always_comb begin
      n_levels = (count_ff == '0) ? CW'(1) : count_ff;
      if (n_levels > LEVELS_MAX) begin
         n_levels = LEVELS_MAX;
      end
      if (n_levels > WORDS_MAX) begin
         n_levels = WORDS_MAX;
      end
   end

   assign ratio_ext = {{(TW-RW){1'b0}}, s1_word_ff.demand_pct};

   // falling: highest level above 0 whose decreasing threshold is below the ratio
   // rising: last level of the leading run whose increasing thresholds are at or below it
   always_comb begin
      sel_fall = '0;
      sel_rise = '0;
      rise_run = 1'b1;
      for (int i = 0; i < NW; i++) begin
         if (i > 0 && IW'(i) < n_levels && dec_thr[i] < ratio_ext) begin
            sel_fall = IW'(i);
         end
         if (rise_run && IW'(i) < n_levels && inc_thr[i] <= ratio_ext) begin
            sel_rise = IW'(i);
         end else begin
            rise_run = 1'b0;
         end
      end
   end

   always_comb begin
      sel = (s1_word_ff.demand_pct < last_ratio_ff) ? sel_fall : sel_rise;
      speed = '0;
      for (int i = 0; i < NW; i++) begin
         if (sel == IW'(i)) begin
            speed = lvl_speed[i];
         end
      end
      if (ratio_ext <= dec_thr[0]) begin
         speed = '0;
      end else if (s1_word_ff.current_target_speed == '0 && ratio_ext < inc_thr[0]) begin
         speed = '0;
      end else if (s1_word_ff.demand_pct == last_ratio_ff) begin
         speed = s1_word_ff.current_target_speed;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_speed_in   = out_speed_ff;
      out_changed_in = out_changed_ff;
      last_ratio_in  = last_ratio_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_speed_in   = speed;
            out_changed_in = (speed != s1_word_ff.current_target_speed);
            last_ratio_in  = s1_word_ff.demand_pct;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            level_ff[i] <= '0;
         end
         count_ff      <= fcurve_pkg::LEVELS_RESET;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_ratio_ff <= '0;
      end else begin
         for (int i = 0; i < NW; i++) begin
            level_ff[i] <= level_in[i];
         end
         count_ff      <= count_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         last_ratio_ff <= last_ratio_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff     <= s1_word_in;
      out_speed_ff   <= out_speed_in;
      out_changed_ff <= out_changed_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_speed_ff;
   assign rsp_tuser[0] = out_changed_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the fan curve lookup: directed table, then random level-table sweeps
module tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_WORDS    = 50;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_CYCLES   = 10;

   typedef logic [fcurve_pkg::RATIO_W-1:0] ratio_type;
   typedef logic [fcurve_pkg::SPEED_W-1:0] speed_type;

   typedef struct packed {
      speed_type speed;
      logic      changed;
   } fan_result_type;

   typedef struct {
      bit                         is_write;
      fcurve_pkg::reg_index_type  reg_sel;
      fcurve_pkg::level_word_type value;
      ratio_type                  ratio;
      speed_type                  cur;
      bit                         typed;
      speed_type                  want_speed;
      logic                       want_changed;
   } step_row_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [23:0]                         req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [15:0]                         rsp_tdata;
   logic [0:0]                          rsp_tuser;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [fcurve_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [fcurve_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [fcurve_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                                csr_pready;

   fan_curve_hysteresis_lookup_top #(.LEVELS(6)) dut (.*);

   // shadow of the level table and the block's ratio history
   fcurve_pkg::level_word_type     level_table [fcurve_pkg::LEVEL_WORDS] = '{default: '0};
   logic [fcurve_pkg::COUNT_W-1:0] levels_used = fcurve_pkg::LEVELS_RESET;
   ratio_type                      prev_ratio = '0;
   speed_type                      fed_back_speed = '0;

   fan_result_type pending_speeds [$];

   int errors = 0;
   int words_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int off_hits = 0;
   int stopped_hits = 0;
   int falling_hits = 0;
   int rising_hits = 0;
   int holding_hits = 0;
   int walk_ratio = 50;
   int idle_cycles = 0;
   bit stall_on = 1'b0;
   bit long_hold_req = 1'b0;

   step_row_type directed_steps [25] = '{
      // reset table: a single all-zero level, so everything comes out off
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd0,   16'd0,    1'b1, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd0,   16'hFFFF, 1'b1, 16'd0,    1'b1},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd127, 16'd1234, 1'b1, 16'd0,    1'b1},
      '{1'b1, fcurve_pkg::REG_LEVEL0, {16'd1000, 8'd30, 8'd20},  7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVEL1, {16'd2000, 8'd45, 8'd35},  7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVEL2, {16'd3000, 8'd60, 8'd50},  7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVEL3, {16'd4000, 8'd75, 8'd65},  7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVEL4, {16'd5000, 8'd90, 8'd80},  7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVEL5, {16'hFFFF, 8'd100, 8'd95}, 7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b1, fcurve_pkg::REG_LEVELS_IN_USE, 32'd6, 7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      // at level 0 falling threshold: off
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd20,  16'd3000, 1'b1, 16'd0,    1'b1},
      // stopped fan below level 0 rising threshold stays off
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd25,  16'd0,    1'b1, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd50,  16'd0,    1'b0, 16'd0,    1'b0},
      // same ratio again keeps the present speed
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd50,  16'd2000, 1'b1, 16'd2000, 1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd40,  16'd2000, 1'b0, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd100, 16'd2000, 1'b0, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd127, 16'hFFFF, 1'b0, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd21,  16'hFFFF, 1'b0, 16'd0,    1'b0},
      // zero level count acts as one level
      '{1'b1, fcurve_pkg::REG_LEVELS_IN_USE, 32'd0, 7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd90,  16'd1000, 1'b0, 16'd0,    1'b0},
      // count past the table is clipped to six
      '{1'b1, fcurve_pkg::REG_LEVELS_IN_USE, 32'd7, 7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd96,  16'd1,    1'b0, 16'd0,    1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd30,  16'd5000, 1'b0, 16'd0,    1'b0},
      // level 0 falling threshold above any ratio: always off
      '{1'b1, fcurve_pkg::REG_LEVEL0, 32'hFFFF_FFFF, 7'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b0, fcurve_pkg::REG_UNUSED, 32'h0, 7'd127, 16'd7,    1'b1, 16'd0,    1'b1}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic fan_result_type next_fan_speed(input ratio_type ratio,
                                                     input speed_type cur);
      int n;
      int lvl;
      fan_result_type res;
      n = int'(levels_used);
      if (n == 0) n = 1;
      if (n > fcurve_pkg::LEVEL_WORDS) n = fcurve_pkg::LEVEL_WORDS;
      if (ratio <= level_table[0][fcurve_pkg::DEC_LSB +: fcurve_pkg::THR_W]) begin
         res.speed = '0;
         off_hits++;
      end else if (cur == '0 &&
                   ratio < level_table[0][fcurve_pkg::INC_LSB +: fcurve_pkg::THR_W]) begin
         res.speed = '0;
         stopped_hits++;
      end else if (ratio < prev_ratio) begin
         lvl = n - 1;
         while (lvl > 0 &&
                level_table[lvl][fcurve_pkg::DEC_LSB +: fcurve_pkg::THR_W] >= ratio) lvl--;
         res.speed = level_table[lvl][fcurve_pkg::SPEED_LSB +: fcurve_pkg::SPEED_W];
         falling_hits++;
      end else if (ratio > prev_ratio) begin
         lvl = 0;
         while (lvl < n &&
                level_table[lvl][fcurve_pkg::INC_LSB +: fcurve_pkg::THR_W] <= ratio) lvl++;
         if (lvl > 0) lvl--;
         res.speed = level_table[lvl][fcurve_pkg::SPEED_LSB +: fcurve_pkg::SPEED_W];
         rising_hits++;
      end else begin
         res.speed = cur;
         holding_hits++;
      end
      res.changed = (res.speed != cur);
      prev_ratio = ratio;
      fed_back_speed = res.speed;
      return res;
   endfunction

   task automatic send_word(input ratio_type ratio, input speed_type cur,
                            input bit typed, input fan_result_type want);
      int gap;
      bit took;
      fcurve_pkg::req_word_type w;
      fan_result_type predicted;
      gap = stall_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.demand_pct = ratio;
      w.current_target_speed = cur;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, w};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      predicted = next_fan_speed(ratio, cur);
      pending_speeds.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_speeds.size() != 0);
   endtask

   // write, then read the register back; starts and ends on a rising edge
   task automatic csr_write(input fcurve_pkg::reg_index_type sel,
                            input fcurve_pkg::level_word_type value);
      bit done;
      fcurve_pkg::level_word_type readback;
      fcurve_pkg::level_word_type stored;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end while (!done);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_pready;
         readback = csr_prdata;
         @(posedge clock);
      end while (!done);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (sel == fcurve_pkg::REG_LEVELS_IN_USE) begin
         levels_used = value[fcurve_pkg::COUNT_W-1:0];
         stored = {{(fcurve_pkg::CSR_DATA_W-fcurve_pkg::COUNT_W){1'b0}},
                   value[fcurve_pkg::COUNT_W-1:0]};
      end else begin
         level_table[sel] = value;
         stored = value;
      end
      csr_writes++;
      if (readback !== stored) begin
         $display("%0t: readback of register %s expected %h got %h",
                  $time, sel.name(), stored, readback);
         errors++;
      end
   endtask

   // ordered tables have rising, nonoverlapping hysteresis bands; the rest is noise
   task automatic load_random_table(input bit ordered);
      int t;
      int dec;
      int inc;
      speed_type spd;
      fcurve_pkg::level_word_type word;
      wait_drained();
      t = $urandom_range(0, 15);
      spd = speed_type'($urandom_range(0, 2000));
      for (int i = 0; i < fcurve_pkg::LEVEL_WORDS; i++) begin
         if (ordered) begin
            dec = t;
            inc = t + $urandom_range(1, 12);
            t = inc + $urandom_range(0, 6);
            spd = speed_type'(spd + $urandom_range(0, 9000));
            word = {spd, inc[7:0], dec[7:0]};
         end else begin
            word = $urandom();
         end
         csr_write(fcurve_pkg::reg_index_type'(i), word);
      end
      if (ordered && $urandom_range(0, 2) != 0)
         csr_write(fcurve_pkg::REG_LEVELS_IN_USE, 32'd6);
      else
         csr_write(fcurve_pkg::REG_LEVELS_IN_USE, $urandom_range(0, 7));
   endtask

   task automatic run_random_phase(input bit ordered, input int count, input bit pause_mid);
      ratio_type ratio;
      speed_type cur;
      int pick;
      for (int k = 0; k < count; k++) begin
         if (pause_mid && k == count / 2) wait_drained();
         if (ordered) begin
            // thermal walk, fed back the way firmware would hand in its last target
            case ($urandom_range(0, 5))
               0: ;
               1, 2: walk_ratio = walk_ratio + $urandom_range(1, 15);
               3, 4: walk_ratio = walk_ratio - $urandom_range(1, 15);
               default: walk_ratio = $urandom_range(0, 127);
            endcase
            if (walk_ratio < 0) walk_ratio = 0;
            if (walk_ratio > 127) walk_ratio = 127;
            ratio = ratio_type'(walk_ratio);
            pick = $urandom_range(0, 9);
            if (pick < 7) cur = fed_back_speed;
            else if (pick == 7) cur = '0;
            else cur = speed_type'($urandom_range(0, 65535));
         end else begin
            ratio = ratio_type'($urandom_range(0, 127));
            cur = ($urandom_range(0, 4) == 0) ? 16'd0 : speed_type'($urandom_range(0, 65535));
         end
         send_word(ratio, cur, 1'b0, '0);
      end
   endtask

   initial begin : result_sink
      int gap;
      bit took;
      fan_result_type got;
      fan_result_type want;
      wait (reset == 1'b0);
      forever begin
         gap = stall_on ? $urandom_range(0, 6) : 0;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            took = rsp_tvalid;
            got.speed = rsp_tdata;
            got.changed = rsp_tuser[0];
            @(posedge clock);
         end while (!took);
         if (pending_speeds.size() == 0) begin
            $display("%0t: unexpected word speed=%0d changed=%0b", $time, got.speed, got.changed);
            errors++;
         end else begin
            want = pending_speeds.pop_front();
            if (got.speed !== want.speed) begin
               $display("%0t: new_target_speed expected %0d got %0d",
                        $time, want.speed, got.speed);
               errors++;
            end
            if (got.changed !== want.changed) begin
               $display("%0t: speed_changed expected %0b got %0b",
                        $time, want.changed, got.changed);
               errors++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** fan_curve_hysteresis_lookup_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      step_row_type row;
      fan_result_type want;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_on = 1'b1;
      foreach (directed_steps[r]) begin
         row = directed_steps[r];
         if (row.is_write) begin
            wait_drained();
            csr_write(row.reg_sel, row.value);
         end else begin
            want.speed = row.want_speed;
            want.changed = row.want_changed;
            send_word(row.ratio, row.cur, row.typed, want);
         end
      end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_table(p % 4 != 3);
         stall_on = (p % 3 != 1);
         // back-pressure burst while the sender streams without gaps
         if (p == 1) long_hold_req = 1'b1;
         run_random_phase(p % 4 != 3, PHASE_WORDS, p == 5);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d words sent, %0d results checked, %0d register writes read back",
               words_sent, results_checked, csr_writes);
      $display("paths: off %0d, stopped fan %0d, falling %0d, rising %0d, held %0d",
               off_hits, stopped_hits, falling_hits, rising_hits, holding_hits);
      if (errors == 0)
         $display("** fan_curve_hysteresis_lookup_top: PASSED **");
      else
         $display("** fan_curve_hysteresis_lookup_top: FAILED **");
      $finish;
   end

endmodule

// ----- fan_curve_hysteresis_lookup_top.f -----
rtl/core/fcurve_pkg.sv
rtl/core/fan_curve_hysteresis_lookup_top.sv
bench/tb.sv
